[rtl/packet_gap_histogram_sequence_monitor_assert.svh]
// assertion macros for the packet gap histogram and sequence monitor
// used by the bound checker only; no dependencies
`ifndef PACKET_GAP_HISTOGRAM_SEQUENCE_MONITOR_ASSERT_SVH
`define PACKET_GAP_HISTOGRAM_SEQUENCE_MONITOR_ASSERT_SVH

// checked only while out of reset
`define PGHSM_ASSERT_RST(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("pghsm assertion failed");

// checked at every edge, reset included
`define PGHSM_ASSERT(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("pghsm assertion failed");

`endif

[rtl/pghsm_pkg.sv]
// shared types, constants and helper functions of the packet gap monitor
// no dependencies
package pghsm_pkg;

  localparam int TIME_WIDTH_DEF = 48;
  localparam int ARRIVAL_W      = 48;
  localparam int ID_W           = 8;
  localparam int CNT_W          = 32;
  localparam int CFG_W          = 16;
  localparam int NUM_BUCKETS    = 6;
  localparam int NUM_BOUNDS     = NUM_BUCKETS - 1;
  localparam int BKT_IDX_W      = $clog2(NUM_BUCKETS);
  localparam int APB_ADDR_W     = 5;
  localparam int APB_DATA_W     = 32;
  localparam int REG_IDX_W      = 3;

  localparam logic [ID_W-1:0] UNTRACKED_ID    = 8'd0;
  localparam logic [ID_W-1:0] MARKER_ID       = 8'd1;
  localparam logic [ID_W-1:0] FIRST_STREAM_ID = 8'd2;

  // ring arithmetic on a 254-entry id ring
  localparam logic [9:0]      RING_1X   = 10'd254;
  localparam logic [9:0]      RING_2X   = 10'd508;
  localparam logic [ID_W-1:0] HALF_RING = 8'd127;

  localparam logic [CFG_W-1:0] PAUSE_LIMIT_RST = 16'd2000;
  localparam logic [NUM_BOUNDS-1:0][CFG_W-1:0] BOUND_RST =
    {16'd100, 16'd50, 16'd20, 16'd10, 16'd5};

  typedef enum logic [REG_IDX_W-1:0] {
    REG_PAUSE_LIMIT = 3'd0,
    REG_BOUND_A     = 3'd1,
    REG_BOUND_B     = 3'd2,
    REG_BOUND_C     = 3'd3,
    REG_BOUND_D     = 3'd4,
    REG_BOUND_E     = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]                  pause_limit;
    logic [NUM_BOUNDS-1:0][CFG_W-1:0]  bound;
  } cfg_t;

  // 256^i mod 125, weights of the bytes of a 64-bit word
  localparam int NUM_BYTES = 8;
  localparam logic [6:0] BYTE_WT [NUM_BYTES] =
    '{7'd1, 7'd6, 7'd36, 7'd91, 7'd46, 7'd26, 7'd31, 7'd61};

  // inverse of an odd value modulo 2^32, newton iteration
  function automatic logic [31:0] inv_mod32(input logic [31:0] a);
    logic [31:0] x;
    x = a;
    for (int i = 0; i < 5; i++) begin
      x = x * (32'd2 - a * x);
    end
    return x;
  endfunction

  localparam logic [31:0] INV125 = inv_mod32(32'd125);

  // residue mod 125 of an 18-bit weighted byte sum
  function automatic logic [6:0] mod125(input logic [17:0] s);
    logic [12:0] t;
    logic [8:0]  u;
    t = 13'(s[17:10]) * 13'd24 + 13'(s[9:0]);
    u = 9'(t[12:7]) * 9'd3 + 9'(t[6:0]);
    if (u >= 9'd250) begin
      u = u - 9'd250;
    end else if (u >= 9'd125) begin
      u = u - 9'd125;
    end
    return u[6:0];
  endfunction

endpackage

[rtl/pghsm_in_if.sv]
// input channel of the packet gap monitor: one frame packet per transfer
// depends on pghsm_pkg
interface pghsm_in_if import pghsm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [ID_W-1:0]      frame_id;
  logic [ARRIVAL_W-1:0] arrival_us;

  modport source (output valid, frame_id, arrival_us, input ready);
  modport sink   (input valid, frame_id, arrival_us, output ready);
endinterface

[rtl/pghsm_out_if.sv]
// result channel of the packet gap monitor: all counters per transfer
// depends on pghsm_pkg
interface pghsm_out_if import pghsm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CNT_W-1:0]     hist_count_0;
  logic [CNT_W-1:0]     hist_count_1;
  logic [CNT_W-1:0]     hist_count_2;
  logic [CNT_W-1:0]     hist_count_3;
  logic [CNT_W-1:0]     hist_count_4;
  logic [CNT_W-1:0]     hist_count_5;
  logic [CNT_W-1:0]     peak_gap_ms;
  logic [ARRIVAL_W-1:0] peak_gap_time_us;
  logic [CNT_W-1:0]     lost_total;
  logic [CNT_W-1:0]     reorder_total;

  modport source (
    output valid, hist_count_0, hist_count_1, hist_count_2, hist_count_3,
           hist_count_4, hist_count_5, peak_gap_ms, peak_gap_time_us,
           lost_total, reorder_total,
    input  ready
  );
  modport sink (
    input  valid, hist_count_0, hist_count_1, hist_count_2, hist_count_3,
           hist_count_4, hist_count_5, peak_gap_ms, peak_gap_time_us,
           lost_total, reorder_total,
    output ready
  );
endinterface

[rtl/pghsm_regs.sv]
// apb register file: pause limit and the five bucket bounds
// depends on pghsm_pkg
module pghsm_regs import pghsm_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  reg_idx_t   idx;
  logic       wr;
  logic [CFG_W-1:0] rd_val;

  assign idx    = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pause_limit <= PAUSE_LIMIT_RST;
      cfg.bound       <= BOUND_RST;
    end else if (wr) begin
      unique case (idx)
        REG_PAUSE_LIMIT: cfg.pause_limit <= pwdata[CFG_W-1:0];
        REG_BOUND_A:     cfg.bound[0]    <= pwdata[CFG_W-1:0];
        REG_BOUND_B:     cfg.bound[1]    <= pwdata[CFG_W-1:0];
        REG_BOUND_C:     cfg.bound[2]    <= pwdata[CFG_W-1:0];
        REG_BOUND_D:     cfg.bound[3]    <= pwdata[CFG_W-1:0];
        REG_BOUND_E:     cfg.bound[4]    <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_PAUSE_LIMIT: rd_val = cfg.pause_limit;
      REG_BOUND_A:     rd_val = cfg.bound[0];
      REG_BOUND_B:     rd_val = cfg.bound[1];
      REG_BOUND_C:     rd_val = cfg.bound[2];
      REG_BOUND_D:     rd_val = cfg.bound[3];
      REG_BOUND_E:     rd_val = cfg.bound[4];
      default:         rd_val = '0;
    endcase
  end

  assign prdata = APB_DATA_W'(rd_val);

endmodule

[rtl/pghsm_gap_div.sv]
// three-stage divide of a microsecond difference by 1000, low 32 bits
// of the quotient; residue mod 125 first, then exact division by inverse
// depends on pghsm_pkg
module pghsm_gap_div import pghsm_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF,
  parameter int TAG_W      = 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [TIME_WIDTH-1:0] in_diff,
  input  logic [TAG_W-1:0]      in_tag,
  output logic                  out_valid,
  output logic [CNT_W-1:0]      out_gap,
  output logic [TAG_W-1:0]      out_tag
);

  logic [63:0]      x;
  logic [17:0]      wsum;
  logic             valid_a, valid_b;
  logic [17:0]      sum_a;
  logic [31:0]      xlo_a, xlo_b;
  logic [6:0]       rem_b;
  logic [TAG_W-1:0] tag_a, tag_b;

  // diff / 1000 == (diff >> 3) / 125
  assign x = 64'(in_diff) >> 3;

  always_comb begin
    wsum = '0;
    for (int i = 0; i < NUM_BYTES; i++) begin
      wsum = wsum + 18'(x[8*i +: 8]) * 18'(BYTE_WT[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a   <= 1'b0;
      valid_b   <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      valid_a   <= in_valid;
      valid_b   <= valid_a;
      out_valid <= valid_b;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sum_a   <= wsum;
      xlo_a   <= x[31:0];
      tag_a   <= in_tag;
      rem_b   <= mod125(sum_a);
      xlo_b   <= xlo_a;
      tag_b   <= tag_a;
      out_gap <= (xlo_b - 32'(rem_b)) * INV125;
      out_tag <= tag_b;
    end
  end

endmodule

[rtl/packet_gap_histogram_sequence_monitor.sv]
// top level of the packet gap histogram and sequence loss monitor
// depends on pghsm_pkg, pghsm_in_if, pghsm_out_if, pghsm_regs, pghsm_gap_div
//
//  channel  dir  handshake            carries
//  frames   in   valid/ready          frame_id, arrival_us
//  stats    out  valid/ready          six bucket counts, peak gap, loss counts
//  apb      in   psel/penable/pready  pause limit, bucket bounds
//
// one packet per cycle while the stats channel is not stalled; a frames transfer is
// registered in the input stage, the three-stage divide by 1000 and the counter stage
// synchronous active-high rst clears all counters and state and resets the apb registers to their defaults
// a stalled stats channel freezes the whole pipeline and drops frames.ready
module packet_gap_histogram_sequence_monitor import pghsm_pkg::*; #(
  parameter int TIME_WIDTH = TIME_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  pghsm_in_if.sink              frames,
  pghsm_out_if.source           stats,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int TAG_W = ID_W + 1 + TIME_WIDTH;

  cfg_t cfg;

  logic                  adv;
  logic                  accept;
  logic [63:0]           arr_ext;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] last_arrival;

  logic                  v1;
  logic [TIME_WIDTH-1:0] diff1;
  logic [TAG_W-1:0]      tag1;

  logic                  v4;
  logic [CNT_W-1:0]      gap4;
  logic [TAG_W-1:0]      tag4;
  logic [ID_W-1:0]       id4;
  logic                  has_gap4;
  logic [TIME_WIDTH-1:0] now4;

  logic [NUM_BUCKETS-1:0][CNT_W-1:0] hist, hist_next;
  logic [CNT_W-1:0]      peak_gap, peak_gap_next;
  logic [TIME_WIDTH-1:0] peak_time, peak_time_next;
  logic [CNT_W-1:0]      lost_count, lost_count_next;
  logic [CNT_W-1:0]      reorder_count, reorder_count_next;
  logic                  seq_armed, seq_armed_next;
  logic [ID_W-1:0]       last_seq_id, last_seq_id_next;
  logic                  out_valid;
  logic [63:0]           peak_ext;

  logic                  armed_tmp;
  logic [NUM_BOUNDS-1:0] above;
  logic [BKT_IDX_W-1:0]  bkt;
  logic [ID_W-1:0]       pos, prev;
  logic [9:0]            ring_d;
  logic [ID_W-1:0]       step;

  pghsm_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign adv          = !(out_valid && !stats.ready);
  assign frames.ready = adv;
  assign accept       = frames.valid && adv;
  assign arr_ext      = 64'(frames.arrival_us);
  assign now          = arr_ext[TIME_WIDTH-1:0];

  // input stage: arrival difference and timing arm state
  always_ff @(posedge clk) begin
    if (rst) begin
      last_arrival <= '0;
      v1           <= 1'b0;
    end else if (adv) begin
      v1 <= frames.valid;
      if (frames.valid) begin
        if (frames.frame_id == MARKER_ID) begin
          last_arrival <= '0;
        end else if (frames.frame_id != UNTRACKED_ID) begin
          last_arrival <= now;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      diff1 <= now - last_arrival;
      tag1  <= {frames.frame_id,
                (frames.frame_id >= FIRST_STREAM_ID) && (last_arrival != '0),
                now};
    end
  end

  pghsm_gap_div #(
    .TIME_WIDTH (TIME_WIDTH),
    .TAG_W      (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (adv),
    .in_valid  (v1),
    .in_diff   (diff1),
    .in_tag    (tag1),
    .out_valid (v4),
    .out_gap   (gap4),
    .out_tag   (tag4)
  );

  assign {id4, has_gap4, now4} = tag4;

  // bucket select: first bound the gap does not exceed
  always_comb begin
    for (int i = 0; i < NUM_BOUNDS; i++) begin
      above[i] = gap4 > CNT_W'(cfg.bound[i]);
    end
    bkt = BKT_IDX_W'(NUM_BOUNDS);
    for (int i = NUM_BOUNDS - 1; i >= 0; i--) begin
      if (!above[i]) begin
        bkt = BKT_IDX_W'(i);
      end
    end
  end

  // forward step on the id ring
  always_comb begin
    pos    = id4 - FIRST_STREAM_ID;
    prev   = last_seq_id - FIRST_STREAM_ID;
    ring_d = 10'(pos) + RING_2X - 10'(prev);
    if (ring_d >= RING_2X) begin
      ring_d = ring_d - RING_2X;
    end
    if (ring_d >= RING_1X) begin
      ring_d = ring_d - RING_1X;
    end
    step = ring_d[ID_W-1:0];
  end

  always_comb begin
    hist_next          = hist;
    peak_gap_next      = peak_gap;
    peak_time_next     = peak_time;
    lost_count_next    = lost_count;
    reorder_count_next = reorder_count;
    seq_armed_next     = seq_armed;
    last_seq_id_next   = last_seq_id;
    armed_tmp          = seq_armed;
    if (v4) begin
      if (id4 == MARKER_ID) begin
        seq_armed_next = 1'b0;
        peak_gap_next  = '0;
        peak_time_next = '0;
      end else if (id4 != UNTRACKED_ID) begin
        if (has_gap4) begin
          if (gap4 > CNT_W'(cfg.pause_limit)) begin
            armed_tmp = 1'b0;
          end else begin
            hist_next[bkt] = hist[bkt] + CNT_W'(1);
            if (gap4 > peak_gap) begin
              peak_gap_next  = gap4;
              peak_time_next = now4;
            end
          end
        end
        if (armed_tmp && step >= HALF_RING) begin
          reorder_count_next = reorder_count + CNT_W'(1);
          if (lost_count != '0) begin
            lost_count_next = lost_count - CNT_W'(1);
          end
        end else begin
          if (armed_tmp && step > 8'd1) begin
            lost_count_next = lost_count + CNT_W'(step) - CNT_W'(1);
          end
          last_seq_id_next = id4;
          seq_armed_next   = 1'b1;
        end
      end
    end
  end

  // counter stage; the state registers are the result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      hist          <= '0;
      peak_gap      <= '0;
      peak_time     <= '0;
      lost_count    <= '0;
      reorder_count <= '0;
      seq_armed     <= 1'b0;
      last_seq_id   <= '0;
      out_valid     <= 1'b0;
    end else if (adv) begin
      hist          <= hist_next;
      peak_gap      <= peak_gap_next;
      peak_time     <= peak_time_next;
      lost_count    <= lost_count_next;
      reorder_count <= reorder_count_next;
      seq_armed     <= seq_armed_next;
      last_seq_id   <= last_seq_id_next;
      out_valid     <= v4;
    end
  end

  assign peak_ext               = 64'(peak_time);
  assign stats.valid            = out_valid;
  assign stats.hist_count_0     = hist[0];
  assign stats.hist_count_1     = hist[1];
  assign stats.hist_count_2     = hist[2];
  assign stats.hist_count_3     = hist[3];
  assign stats.hist_count_4     = hist[4];
  assign stats.hist_count_5     = hist[5];
  assign stats.peak_gap_ms      = peak_gap;
  assign stats.peak_gap_time_us = peak_ext[ARRIVAL_W-1:0];
  assign stats.lost_total       = lost_count;
  assign stats.reorder_total    = reorder_count;

endmodule

[rtl/pghsm_sva.sv]
// port-level assertions of the packet gap monitor, bound to the top level
// depends on pghsm_pkg, the interfaces and the assertion macro header
`include "packet_gap_histogram_sequence_monitor_assert.svh"

module pghsm_sva import pghsm_pkg::*; (
  input logic         clk,
  input logic         rst,
  pghsm_in_if.sink    frames,
  pghsm_out_if.source stats
);

  // stalled result stays valid and holds its loss count
  `PGHSM_ASSERT_RST(a_stall_hold, clk, rst,
    stats.valid && !stats.ready |=> stats.valid && $stable(stats.lost_total))

  // no result right after reset
  `PGHSM_ASSERT(a_reset_quiet, clk, rst |=> !stats.valid && frames.ready)

  // reorder count only steps by one
  `PGHSM_ASSERT_RST(a_reorder_step, clk, rst,
    !$past(rst) && !$stable(stats.reorder_total) |->
      stats.reorder_total == $past(stats.reorder_total) + 32'd1)

  // at most one bucket counts per packet
  `PGHSM_ASSERT_RST(a_one_bucket, clk, rst,
    !$past(rst) |-> $countones({!$stable(stats.hist_count_5), !$stable(stats.hist_count_4),
                                !$stable(stats.hist_count_3), !$stable(stats.hist_count_2),
                                !$stable(stats.hist_count_1),
                                !$stable(stats.hist_count_0)}) <= 1)

  // no peak time without a peak
  `PGHSM_ASSERT_RST(a_peak_time_zero, clk, rst,
    stats.peak_gap_ms == 32'd0 |-> stats.peak_gap_time_us == 48'd0)

endmodule

bind packet_gap_histogram_sequence_monitor pghsm_sva u_sva (
  .clk    (clk),
  .rst    (rst),
  .frames (frames),
  .stats  (stats)
);
